### hdl/kfst_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kfst_pkg
// Shared types and constants for the keyed file slot table.
// ----------------------------------------------------------------------------
package kfst_pkg;

  localparam int DefSlotCount     = 16;
  localparam int DefCapacityBytes = 32768;
  localparam int DefReservedBytes = 512;
  localparam int QueueDepth       = 2;

  typedef enum logic [2:0] {
    MODE_FORMAT = 3'd0,
    MODE_ALLOC  = 3'd1,
    MODE_FIND   = 3'd2,
    MODE_DELETE = 3'd3,
    MODE_STATE  = 3'd4,
    MODE_SPACE  = 3'd5
  } mode_e;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_BAD_SLOT = 2'd1,
    ST_NO_SPACE = 2'd2,
    ST_NO_MATCH = 2'd3
  } status_e;

  typedef enum logic [1:0] {
    BK_IDLE,
    BK_SCAN,
    BK_DONE
  } back_state_e;

  // classified command handed from front to back
  typedef struct packed {
    logic [2:0]  mode;
    logic [15:0] company;
    logic [31:0] game;
    logic [31:0] game_label;
    logic [31:0] ext_label;
    logic [15:0] req_size;
    logic [16:0] req_round;
    logic [3:0]  slot_index;
  } cmd_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [3:0]  found_slot;
    logic [15:0] file_size;
    logic [15:0] file_company;
    logic [31:0] file_game;
    logic [31:0] file_ext;
    logic [14:0] free_bytes;
    logic [4:0]  live_files;
  } res_t;

endpackage

### hdl/kfst_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kfst_front
// Accepts requests, rounds the allocation size and pushes into a short queue.
// ----------------------------------------------------------------------------
module kfst_front import kfst_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [2:0]  mode_i,
  input  logic [15:0] company_code_i,
  input  logic [31:0] game_code_i,
  input  logic [31:0] game_label_i,
  input  logic [31:0] ext_label_i,
  input  logic [15:0] request_size_i,
  input  logic [3:0]  slot_index_i,
  output logic        cmd_valid_o,
  input  logic        cmd_pop_i,
  output cmd_t        cmd_o
);
  cmd_t       mem_q [QueueDepth];
  logic       wp_q, rp_q;
  logic [1:0] cnt_q;
  logic       push;
  cmd_t       c;

  assign in_stall    = (cnt_q == 2'(QueueDepth));
  assign push        = in_valid && !in_stall;
  assign cmd_valid_o = (cnt_q != 2'd0);
  assign cmd_o       = mem_q[rp_q];

  always_comb begin
    c            = '0;
    c.mode       = mode_i;
    c.company    = company_code_i;
    c.game       = game_code_i;
    c.game_label = game_label_i;
    c.ext_label  = ext_label_i;
    c.req_size   = request_size_i;
    c.req_round  = ({1'b0, request_size_i} + 17'h00FF) & 17'h1FF00;
    c.slot_index = slot_index_i;
  end

  always_ff @(posedge clk_i) begin
    if (push) mem_q[wp_q] <= c;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q <= 1'b0;
      rp_q <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      if (push) wp_q <= ~wp_q;
      if (cmd_pop_i) rp_q <= ~rp_q;
      cnt_q <= cnt_q + 2'(push) - 2'(cmd_pop_i);
    end
  end
endmodule

### hdl/kfst_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kfst_back
// Executes commands: scans slots one per cycle, keeps totals, holds result.
// ----------------------------------------------------------------------------
module kfst_back import kfst_pkg::*; #(
  parameter int SLOT_COUNT     = DefSlotCount,
  parameter int CAPACITY_BYTES = DefCapacityBytes,
  parameter int RESERVED_BYTES = DefReservedBytes
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic cmd_valid_i,
  output logic cmd_pop_o,
  input  cmd_t cmd_i,
  output logic res_valid_o,
  input  logic res_stall_i,
  output res_t res_o
);
  localparam int IW = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
  localparam int CW = $clog2(SLOT_COUNT + 1);

  logic [SLOT_COUNT-1:0] used_q;
  logic [15:0]  size_q [SLOT_COUNT];
  logic [111:0] key_q  [SLOT_COUNT];
  logic [17:0]  sum_q;    // uncapped reserved + rounded live sizes
  logic [CW-1:0] live_q;
  logic [IW-1:0] idx_q;
  back_state_e  st_q, st_d;
  res_t         res_q;

  logic [16:0] used_cap;
  logic [111:0] key_in;
  logic        slot_hit, last;
  logic [16:0] sz_round;

  assign key_in   = {cmd_i.company, cmd_i.game, cmd_i.game_label, cmd_i.ext_label};
  assign used_cap = (sum_q > 18'(CAPACITY_BYTES)) ? 17'(CAPACITY_BYTES) : sum_q[16:0];
  assign last     = (32'(idx_q) == SLOT_COUNT - 1);
  assign sz_round = ({1'b0, size_q[idx_q]} + 17'h00FF) & 17'h1FF00;

  always_comb begin
    if (cmd_i.mode == MODE_ALLOC) slot_hit = !used_q[idx_q];
    else slot_hit = used_q[idx_q] && (key_q[idx_q] == key_in);
  end

  assign res_valid_o = (st_q == BK_DONE);
  assign res_o       = res_q;
  assign cmd_pop_o   = (st_q == BK_DONE) && !res_stall_i;

  always_comb begin
    st_d = st_q;
    case (st_q)
      BK_IDLE: if (cmd_valid_i) st_d = BK_SCAN;
      BK_SCAN: begin
        if (cmd_i.mode inside {MODE_ALLOC, MODE_FIND, MODE_DELETE}) begin
          if (cmd_i.mode == MODE_ALLOC &&
              ({1'b0, used_cap} + {1'b0, cmd_i.req_round}) > 18'(CAPACITY_BYTES))
            st_d = BK_DONE;
          else if (slot_hit || last) st_d = BK_DONE;
        end else st_d = BK_DONE;
      end
      BK_DONE: if (!res_stall_i) st_d = BK_IDLE;
      default: st_d = BK_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q   <= BK_IDLE;
      used_q <= '0;
      sum_q  <= 18'(RESERVED_BYTES);
      live_q <= '0;
      idx_q  <= '0;
    end else begin
      st_q <= st_d;
      if (st_q == BK_IDLE) idx_q <= '0;
      if (st_q == BK_SCAN) begin
        idx_q <= idx_q + IW'(1);
        case (cmd_i.mode)
          MODE_FORMAT: begin
            used_q <= '0;
            sum_q  <= 18'(RESERVED_BYTES);
            live_q <= '0;
          end
          MODE_ALLOC: begin
            if (({1'b0, used_cap} + {1'b0, cmd_i.req_round}) <= 18'(CAPACITY_BYTES) &&
                slot_hit) begin
              used_q[idx_q] <= 1'b1;
              sum_q  <= sum_q + 18'(cmd_i.req_round);
              live_q <= live_q + CW'(1);
            end
          end
          MODE_DELETE: begin
            if (slot_hit) begin
              used_q[idx_q] <= 1'b0;
              sum_q  <= sum_q - 18'(sz_round);
              live_q <= live_q - CW'(1);
            end
          end
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (st_q == BK_SCAN) begin
      if (cmd_i.mode == MODE_FORMAT) begin
        for (int i = 0; i < SLOT_COUNT; i++) size_q[i] <= '0;
      end else if (cmd_i.mode == MODE_ALLOC && slot_hit &&
          ({1'b0, used_cap} + {1'b0, cmd_i.req_round}) <= 18'(CAPACITY_BYTES)) begin
        size_q[idx_q] <= cmd_i.req_size;
        key_q[idx_q]  <= key_in;
      end else if (cmd_i.mode == MODE_DELETE && slot_hit) begin
        size_q[idx_q] <= '0;
      end
    end
  end

  // result built during the final scan cycle
  always_ff @(posedge clk_i) begin
    if (st_q == BK_SCAN && st_d == BK_DONE) begin
      res_q <= '0;
      case (cmd_i.mode)
        MODE_FORMAT: ;
        MODE_ALLOC: begin
          if (({1'b0, used_cap} + {1'b0, cmd_i.req_round}) > 18'(CAPACITY_BYTES) ||
              !slot_hit)
            res_q.status <= ST_NO_SPACE;
          else res_q.found_slot <= 4'(idx_q);
        end
        MODE_FIND, MODE_DELETE: begin
          if (slot_hit) res_q.found_slot <= 4'(idx_q);
          else res_q.status <= ST_NO_MATCH;
        end
        MODE_STATE: begin
          if (32'(cmd_i.slot_index) >= SLOT_COUNT ||
              !used_q[IW'(cmd_i.slot_index)])
            res_q.status <= ST_BAD_SLOT;
          else begin
            res_q.file_size    <= size_q[IW'(cmd_i.slot_index)];
            res_q.file_company <= key_q[IW'(cmd_i.slot_index)][111:96];
            res_q.file_game    <= key_q[IW'(cmd_i.slot_index)][95:64];
            res_q.file_ext     <= key_q[IW'(cmd_i.slot_index)][31:0];
          end
        end
        MODE_SPACE: begin
          res_q.free_bytes <= 15'(17'(CAPACITY_BYTES) - used_cap);
          res_q.live_files <= 5'(live_q);
        end
        default: res_q.status <= ST_BAD_SLOT;
      endcase
    end
  end
endmodule

### hdl/keyed_file_slot_table.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// keyed_file_slot_table
// Sixteen keyed file slots with allocate, find, delete and space queries.
// ----------------------------------------------------------------------------
// Input channel in_valid/in_stall carries one request per transfer; the
// output channel out_valid/out_stall returns exactly one result for each.
// A two-entry queue sits between the front end and the execution unit, so
// requests are taken while a result waits in the output register.
// Allocate, find and delete scan the slots one per cycle in the execution
// unit, stopping at the first hit; allocate also stops when the rounded
// size does not fit. Format, state and space queries do not walk the slots.
// A command leaves the queue only once its result is taken.
// Reset empties the queue, marks every slot free and sets the used total to
// the reserved bytes; slot keys are not cleared.
// While out_stall is high the result holds and the execution unit waits;
// once the queue fills, in_stall rises.
// ----------------------------------------------------------------------------
module keyed_file_slot_table import kfst_pkg::*; #(
  parameter int SLOT_COUNT     = DefSlotCount,
  parameter int CAPACITY_BYTES = DefCapacityBytes,
  parameter int RESERVED_BYTES = DefReservedBytes
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [2:0]  mode_i,
  input  logic [15:0] company_code_i,
  input  logic [31:0] game_code_i,
  input  logic [31:0] game_label_i,
  input  logic [31:0] ext_label_i,
  input  logic [15:0] request_size_i,
  input  logic [3:0]  slot_index_i,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [1:0]  status_o,
  output logic [3:0]  found_slot_o,
  output logic [15:0] file_size_o,
  output logic [15:0] file_company_o,
  output logic [31:0] file_game_o,
  output logic [31:0] file_ext_o,
  output logic [14:0] free_bytes_o,
  output logic [4:0]  live_files_o
);
  logic cmd_valid, cmd_pop;
  cmd_t cmd;
  res_t res;

  kfst_front u_front (
    .clk_i, .rst_ni, .in_valid, .in_stall, .mode_i, .company_code_i,
    .game_code_i, .game_label_i, .ext_label_i, .request_size_i, .slot_index_i,
    .cmd_valid_o(cmd_valid), .cmd_pop_i(cmd_pop), .cmd_o(cmd)
  );

  kfst_back #(
    .SLOT_COUNT(SLOT_COUNT), .CAPACITY_BYTES(CAPACITY_BYTES),
    .RESERVED_BYTES(RESERVED_BYTES)
  ) u_back (
    .clk_i, .rst_ni, .cmd_valid_i(cmd_valid), .cmd_pop_o(cmd_pop), .cmd_i(cmd),
    .res_valid_o(out_valid), .res_stall_i(out_stall), .res_o(res)
  );

  assign status_o       = res.status;
  assign found_slot_o   = res.found_slot;
  assign file_size_o    = res.file_size;
  assign file_company_o = res.file_company;
  assign file_game_o    = res.file_game;
  assign file_ext_o     = res.file_ext;
  assign free_bytes_o   = res.free_bytes;
  assign live_files_o   = res.live_files;

  a_pop_needs_cmd: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_pop |-> cmd_valid) else $error("pop without queued command");
  a_result_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && out_stall |=> out_valid && $stable(status_o) && $stable(found_slot_o))
    else $error("stalled result changed");
  a_live_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid |-> live_files_o <= 5'(SLOT_COUNT)) else $error("live count too big");
endmodule
